// ===== sv/efp_pkg.sv =====
// Shared constants and item types for the equal partition fixer.
package efp_pkg;

   // Default sizing of the block
   localparam int EFP_MAX_ITEMS  = 32;
   localparam int EFP_VALUE_BITS = 8;
   localparam int EFP_SUM_BITS   = 8192;
   localparam int EFP_WORD_BITS  = 64;

   // Fixed field widths of the item channels
   localparam int ITEM_VALUE_BITS = 8;
   localparam int POS_BITS        = 6;

   // One input item
   typedef struct packed {
      logic [ITEM_VALUE_BITS-1:0] item_value;
      logic                       last_item;
   } req_type;

   // One result item
   typedef struct packed {
      logic                remove_count;
      logic [POS_BITS-1:0] remove_position;
      logic                too_many;
   } rsp_type;

endpackage

// ===== sv/efp_div.sv =====
// Split of an unsigned operand by a power-of-two constant into quotient and remainder.
module efp_div #(
   parameter int DW      = 16,
   parameter int DIVISOR = 64
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [DW-1:0]                operand,
   output logic                         done,
   output logic [DW-1:0]                quot,
   output logic [$clog2(DIVISOR)-1:0]   rem
);

   // DIVISOR is a power of two
   localparam int RW = $clog2(DIVISOR);

   logic          done_ff;
   logic [DW-1:0] quo_ff;
   logic [RW-1:0] rem_ff;

   // Result is ready in the cycle after start
   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= start;
      end
   end

   // Quotient is the operand shifted down, remainder its low bits
   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= operand >> RW;
         rem_ff <= operand[RW-1:0];
      end
   end

   assign done = done_ff;
   assign quot = quo_ff;
   assign rem  = rem_ff;

endmodule

// ===== sv/efp_reach_mem.sv =====
// Reachable-sum bitset memory: two registered read ports, one write port, valid bits.
module efp_reach_mem #(
   parameter int NUM_WORDS = 128,
   parameter int WORD_BITS = 64,
   parameter int AW        = 7
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 clear,
   input  logic [AW-1:0]        rd_addr_a,
   input  logic [AW-1:0]        rd_addr_b,
   output logic [WORD_BITS-1:0] rd_data_a,
   output logic [WORD_BITS-1:0] rd_data_b,
   input  logic                 wr_en,
   input  logic [AW-1:0]        wr_addr,
   input  logic [WORD_BITS-1:0] wr_data
);

   logic [WORD_BITS-1:0] mem [NUM_WORDS];
   logic [NUM_WORDS-1:0] vld_ff;
   logic [WORD_BITS-1:0] raw_a_ff;
   logic [WORD_BITS-1:0] raw_b_ff;
   logic                 vld_a_ff;
   logic                 vld_b_ff;
   logic                 zero_a_ff;
   logic                 zero_b_ff;

   // Storage array
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      raw_a_ff <= mem[rd_addr_a];
      raw_b_ff <= mem[rd_addr_b];
   end

   // Per-word valid bits; an unwritten word reads as the cleared bitset
   always_ff @(posedge clock) begin
      if (reset || clear) begin
         vld_ff <= '0;
      end else if (wr_en) begin
         vld_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      vld_a_ff  <= vld_ff[rd_addr_a];
      vld_b_ff  <= vld_ff[rd_addr_b];
      zero_a_ff <= (rd_addr_a == '0);
      zero_b_ff <= (rd_addr_b == '0);
   end

   // Only sum zero is reachable in a cleared set
   assign rd_data_a = vld_a_ff ? raw_a_ff : (zero_a_ff ? WORD_BITS'(1) : '0);
   assign rd_data_b = vld_b_ff ? raw_b_ff : (zero_b_ff ? WORD_BITS'(1) : '0);

endmodule

// ===== sv/equal_partition_fixer.sv =====
// Top level of the equal partition fixer: sequencer, scalar state and result register.
//
// Items arrive one per set element; the one with last_item set closes the set and
// produces exactly one result, after which all state is cleared. Every nonzero value
// within capacity walks the reachable-sum bitset memory once, one word per cycle from
// the top word down to word value/WORD_BITS, and holds the input while it does; zero
// values, items past capacity and a value past the bitset skip the walk. A closing item
// adds the half-sum lookup through the divider and the memory, which is skipped when the
// set overflowed, has no nonzero value, an odd sum or a half sum past the bitset.
// The word walk through the memory's single write port sets the item rate.
// WORD_BITS must be a power of two. The result sits in an output register, so a
// new set can start while it waits to be taken; the next closing item stalls the
// input until that register is free.
module equal_partition_fixer import efp_pkg::*; #(
   parameter int MAX_ITEMS  = EFP_MAX_ITEMS,
   parameter int VALUE_BITS = EFP_VALUE_BITS,
   parameter int SUM_BITS   = EFP_SUM_BITS,
   parameter int WORD_BITS  = EFP_WORD_BITS
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int NUM_WORDS = (SUM_BITS + WORD_BITS - 1) / WORD_BITS;
   localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
   localparam int RW        = $clog2(WORD_BITS);
   localparam int CW        = $clog2(MAX_ITEMS + 1);
   localparam int MAX_SUM   = MAX_ITEMS * ((1 << VALUE_BITS) - 1);
   localparam int SW        = $clog2(MAX_SUM + 1);
   localparam int HW        = SW - 1;
   localparam int DW        = (VALUE_BITS > $clog2(SUM_BITS)) ? VALUE_BITS : $clog2(SUM_BITS);
   localparam int TZW       = $clog2(VALUE_BITS);
   localparam int PW        = (CW > POS_BITS) ? CW : POS_BITS;

   // Sequencer states
   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_DIV   = 4'd1;
   localparam logic [3:0] S_PRIME = 4'd2;
   localparam logic [3:0] S_WALK  = 4'd3;
   localparam logic [3:0] S_DRAIN = 4'd4;
   localparam logic [3:0] S_CHECK = 4'd5;
   localparam logic [3:0] S_CDIV  = 4'd6;
   localparam logic [3:0] S_CWAIT = 4'd7;
   localparam logic [3:0] S_RESP  = 4'd8;

   logic [3:0]           state_ff, state_in;
   logic [SW-1:0]        sum_ff, sum_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [TZW-1:0]       fewest_ff, fewest_in;
   logic [CW-1:0]        best_ff, best_in;
   logic                 ovf_ff, ovf_in;
   logic                 last_ff, last_in;
   logic [AW-1:0]        q_ff, q_in;
   logic [RW-1:0]        r_ff, r_in;
   logic [AW-1:0]        dst_ff, dst_in;
   logic                 w_valid_ff, w_valid_in;
   logic [AW-1:0]        w_addr_ff, w_addr_in;
   logic                 w_lo_ok_ff, w_lo_ok_in;
   logic [WORD_BITS-1:0] hi_ff, hi_in;
   rsp_type              pend_ff, pend_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;

   logic [VALUE_BITS-1:0] value;
   logic [TZW-1:0]        tz;
   logic                  div_start;
   logic [DW-1:0]         div_operand;
   logic                  div_done;
   logic [DW-1:0]         div_quot;
   logic [RW-1:0]         div_rem;
   logic [AW-1:0]         rd_addr_a;
   logic [WORD_BITS-1:0]  rd_data_a;
   logic [WORD_BITS-1:0]  rd_data_b;
   logic                  wr_en;
   logic [WORD_BITS-1:0]  wr_data;
   logic                  mem_clear;
   logic [HW-1:0]         half_sum;
   logic [WORD_BITS-1:0]  shl;
   logic [WORD_BITS-1:0]  shr;
   logic [RW:0]           shift_amt;
   logic [PW-1:0]         best_pos_x;
   logic                  hit;

   efp_div #(
      .DW      (DW),
      .DIVISOR (WORD_BITS)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .operand (div_operand),
      .done    (div_done),
      .quot    (div_quot),
      .rem     (div_rem)
   );

   efp_reach_mem #(
      .NUM_WORDS (NUM_WORDS),
      .WORD_BITS (WORD_BITS),
      .AW        (AW)
   ) u_mem (
      .clock     (clock),
      .reset     (reset),
      .clear     (mem_clear),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (dst_ff),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b),
      .wr_en     (wr_en),
      .wr_addr   (w_addr_ff),
      .wr_data   (wr_data)
   );

   assign value      = VALUE_BITS'(req_data.item_value);
   assign half_sum   = sum_ff[SW-1:1];
   assign best_pos_x = PW'(best_ff);
   assign hit        = rd_data_a[r_ff];

   // Lowest set bit of the value
   always_comb begin
      tz = '0;
      for (int i = VALUE_BITS - 1; i >= 0; i--) begin
         if (value[i]) begin
            tz = TZW'(i);
         end
      end
   end

   // Merge: dest | (hi << r) | (lo >> (W - r))
   assign shift_amt = (RW+1)'(WORD_BITS) - (RW+1)'(r_ff);
   assign shl       = hi_ff << r_ff;
   assign shr       = ((r_ff != '0) && w_lo_ok_ff) ? (rd_data_a >> shift_amt) : '0;
   assign wr_data   = rd_data_b | shl | shr;
   assign wr_en     = w_valid_ff;

   assign req_stall = (state_ff != S_IDLE);

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      sum_in       = sum_ff;
      count_in     = count_ff;
      fewest_in    = fewest_ff;
      best_in      = best_ff;
      ovf_in       = ovf_ff;
      last_in      = last_ff;
      q_in         = q_ff;
      r_in         = r_ff;
      dst_in       = dst_ff;
      w_valid_in   = w_valid_ff;
      w_addr_in    = w_addr_ff;
      w_lo_ok_in   = w_lo_ok_ff;
      hi_in        = hi_ff;
      pend_in      = pend_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      div_start    = 1'b0;
      div_operand  = DW'(value);
      rd_addr_a    = '0;
      mem_clear    = 1'b0;

      // Output slot drains independently
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               last_in  = req_data.last_item;
               state_in = S_CHECK;
               if (!ovf_ff) begin
                  if (count_ff >= CW'(MAX_ITEMS)) begin
                     ovf_in = 1'b1;
                  end else begin
                     count_in = count_ff + CW'(1);
                     if (value != '0) begin
                        sum_in = sum_ff + SW'(value);
                        if ((best_ff == '0) || (tz < fewest_ff)) begin
                           fewest_in = tz;
                           best_in   = count_ff + CW'(1);
                        end
                        div_start = 1'b1;
                        state_in  = S_DIV;
                     end
                  end
               end
            end
         end
         S_DIV: begin
            if (div_done) begin
               if (32'(div_quot) >= NUM_WORDS) begin
                  state_in = S_CHECK;
               end else begin
                  q_in     = AW'(div_quot);
                  r_in     = div_rem;
                  dst_in   = AW'(NUM_WORDS - 1);
                  state_in = S_PRIME;
               end
            end
         end
         S_PRIME: begin
            // fetch the source word for the top destination
            rd_addr_a  = AW'(NUM_WORDS - 1) - q_ff;
            w_valid_in = 1'b0;
            state_in   = S_WALK;
         end
         S_WALK: begin
            // read lower source word and destination, write the previous one
            rd_addr_a  = (dst_ff != q_ff) ? (dst_ff - q_ff - AW'(1)) : '0;
            w_valid_in = 1'b1;
            w_addr_in  = dst_ff;
            w_lo_ok_in = (dst_ff != q_ff);
            hi_in      = rd_data_a;
            if (dst_ff == q_ff) begin
               state_in = S_DRAIN;
            end else begin
               dst_in = dst_ff - AW'(1);
            end
         end
         S_DRAIN: begin
            w_valid_in = 1'b0;
            state_in   = S_CHECK;
         end
         S_CHECK: begin
            if (!last_ff) begin
               state_in = S_IDLE;
            end else if (ovf_ff) begin
               pend_in.remove_count    = 1'b0;
               pend_in.remove_position = '0;
               pend_in.too_many        = 1'b1;
               state_in                = S_RESP;
            end else if ((best_ff == '0) || sum_ff[0] || (32'(half_sum) >= SUM_BITS)) begin
               pend_in.remove_count    = 1'b0;
               pend_in.remove_position = '0;
               pend_in.too_many        = 1'b0;
               state_in                = S_RESP;
            end else begin
               div_start   = 1'b1;
               div_operand = DW'(half_sum);
               state_in    = S_CDIV;
            end
         end
         S_CDIV: begin
            // word of the half sum is read as soon as the quotient is ready
            rd_addr_a = AW'(div_quot);
            if (div_done) begin
               r_in     = div_rem;
               state_in = S_CWAIT;
            end
         end
         S_CWAIT: begin
            pend_in.remove_count    = hit;
            pend_in.remove_position = hit ? best_pos_x[POS_BITS-1:0] : '0;
            pend_in.too_many        = 1'b0;
            state_in                = S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = pend_ff;
               sum_in       = '0;
               count_in     = '0;
               fewest_in    = '1;
               best_in      = '0;
               ovf_in       = 1'b0;
               last_in      = 1'b0;
               mem_clear    = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         sum_ff       <= '0;
         count_ff     <= '0;
         fewest_ff    <= '1;
         best_ff      <= '0;
         ovf_ff       <= 1'b0;
         w_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         fewest_ff    <= fewest_in;
         best_ff      <= best_in;
         ovf_ff       <= ovf_in;
         w_valid_ff   <= w_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      last_ff     <= last_in;
      q_ff        <= q_in;
      r_ff        <= r_in;
      dst_ff      <= dst_in;
      w_addr_ff   <= w_addr_in;
      w_lo_ok_ff  <= w_lo_ok_in;
      hi_ff       <= hi_in;
      pend_ff     <= pend_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
